// ===== rtl/core/robin_hood_hash_table_top_defines.svh =====
// assertion macros for the hash table rtl
`ifndef ROBIN_HOOD_HASH_TABLE_TOP_DEFINES_SVH
`define ROBIN_HOOD_HASH_TABLE_TOP_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define RH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// next-cycle implication checked outside reset
`define RH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rhht_pkg.sv =====
`default_nettype none
package rhht_pkg;
  localparam int unsigned Slots    = 256;
  localparam int unsigned SlotBits = 8;
  localparam int unsigned KeyBits  = 32;
  localparam int unsigned DataBits = 32;
  localparam int unsigned CntBits  = 9;

  localparam logic [2:0] CmdLookup = 3'd0;
  localparam logic [2:0] CmdInsert = 3'd1;
  localparam logic [2:0] CmdUpdate = 3'd2;
  localparam logic [2:0] CmdUpsert = 3'd3;
  localparam logic [2:0] CmdRemove = 3'd4;
  localparam logic [2:0] CmdClear  = 3'd5;

  localparam logic [2:0] StFound    = 3'd0;
  localparam logic [2:0] StNotFound = 3'd1;
  localparam logic [2:0] StInserted = 3'd2;
  localparam logic [2:0] StDup      = 3'd3;
  localparam logic [2:0] StUpdated  = 3'd4;
  localparam logic [2:0] StRemoved  = 3'd5;
  localparam logic [2:0] StFull     = 3'd6;
  localparam logic [2:0] StCleared  = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE, S_PRD, S_PCHK, S_PLD, S_PLCHK, S_RMD, S_RMCHK, S_CLR, S_OUT
  } state_e;

  typedef struct packed {
    logic [KeyBits-1:0]  key;
    logic [31:0]         hash;
    logic [DataBits-1:0] data;
  } slot_t;

  // distance of an entry at slot p whose hash is h
  function automatic logic [SlotBits-1:0] dist_of(logic [SlotBits-1:0] p, logic [31:0] h);
    dist_of = p - h[SlotBits-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/rhht_cmd_if.sv =====
`default_nettype none
interface rhht_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] key;
  logic [31:0] hash_value;
  logic [31:0] data_in;
  modport source (output valid, command, key, hash_value, data_in, input ready);
  modport sink (input valid, command, key, hash_value, data_in, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rhht_rsp_if.sv =====
`default_nettype none
interface rhht_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] entry_data;
  logic [8:0]  entry_count;
  modport source (output valid, status, entry_data, entry_count, input ready);
  modport sink (input valid, status, entry_data, entry_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rhht_slot_ram.sv =====
`default_nettype none
module rhht_slot_ram (
  input  wire logic                              clk_i,
  input  wire logic                              we_i,
  input  wire logic [rhht_pkg::SlotBits-1:0]     waddr_i,
  input  wire rhht_pkg::slot_t                   wdata_i,
  input  wire logic [rhht_pkg::SlotBits-1:0]     raddr_i,
  output rhht_pkg::slot_t                        rdata_o
);
  rhht_pkg::slot_t mem_q [rhht_pkg::Slots];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/core/robin_hood_hash_table_top.sv =====
// robin hood hash table, one command at a time through one slot memory with a read and a write port
// a command probes from its home slot, each probed slot is read and then checked
// insert or upsert then walks on placing and displacing entries, remove shifts its followers back
// a new command is accepted only in idle, which the input reopens from after the result is accepted
// clear sweeps all valid bits at once; unused codes go straight to the result
// reset: async active low, all valid bits and the count zero, limit set to 192
`default_nettype none
`include "robin_hood_hash_table_top_defines.svh"
module robin_hood_hash_table_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  rhht_cmd_if.sink        cmd,
  rhht_rsp_if.source      rsp
);
  localparam int unsigned SB = rhht_pkg::SlotBits;

  rhht_pkg::state_e state_q, state_d;

  logic [7:0] max_q;
  logic [rhht_pkg::Slots-1:0] valid_q;
  logic [rhht_pkg::CntBits-1:0] count_q;

  // command code latched at accept
  logic [2:0]  cmd_q;
  rhht_pkg::slot_t cur_q, cur_d;     // entry being placed or probed for
  logic [SB-1:0] pos_q, pos_d;
  logic [SB-1:0] dist_q, dist_d;
  logic [SB:0]   steps_q, steps_d;   // bounded walk guard

  logic [2:0]  status_q, status_d;
  logic [31:0] edata_q, edata_d;
  logic        rsp_valid_q;

  // memory port
  logic          we;
  logic [SB-1:0] waddr, raddr;
  rhht_pkg::slot_t wdata, rdata;

  rhht_slot_ram u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [SB-1:0] nxt_pos, res_dist;
  logic          hit, full;
  logic          set_v, clr_v, clr_all, cnt_inc, cnt_dec;
  logic [SB-1:0] nxt_q;
  logic [rhht_pkg::Slots-1:0] set_mask, clr_mask;

  assign nxt_pos  = pos_q + 1'b1;
  assign res_dist = rhht_pkg::dist_of(pos_q, rdata.hash);
  assign hit      = valid_q[pos_q] && rdata.hash == cur_q.hash && rdata.key == cur_q.key;
  assign full     = (count_q >= {1'b0, max_q}) || (count_q >= rhht_pkg::CntBits'(rhht_pkg::Slots));
  assign nxt_q    = nxt_pos;
  assign raddr    = pos_d;

  // one-hot set at waddr, clear at pos_q; a shift clears the follower and sets the slot before it
  assign set_mask = set_v ? (rhht_pkg::Slots'(1) << waddr) : '0;
  assign clr_mask = clr_v ? (rhht_pkg::Slots'(1) << pos_q) : '0;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rhht_pkg::S_IDLE: begin
        if (cmd.valid) begin
          if (cmd.command == rhht_pkg::CmdClear) state_d = rhht_pkg::S_CLR;
          else if (cmd.command > rhht_pkg::CmdRemove) state_d = rhht_pkg::S_OUT;
          else state_d = rhht_pkg::S_PRD;
        end
      end
      rhht_pkg::S_PRD:   state_d = rhht_pkg::S_PCHK;
      rhht_pkg::S_PCHK: begin
        if (!valid_q[pos_q] || hit || dist_q > res_dist || steps_q[SB]) begin
          state_d = rhht_pkg::S_OUT;
          if (!hit && !full && (cmd_q == rhht_pkg::CmdInsert || cmd_q == rhht_pkg::CmdUpsert))
            state_d = rhht_pkg::S_PLCHK;
          if (hit && cmd_q == rhht_pkg::CmdRemove) state_d = rhht_pkg::S_RMD;
        end else begin
          state_d = rhht_pkg::S_PRD;
        end
      end
      rhht_pkg::S_PLD:   state_d = rhht_pkg::S_PLCHK;
      rhht_pkg::S_PLCHK: state_d = !valid_q[pos_q] ? rhht_pkg::S_OUT : rhht_pkg::S_PLD;
      rhht_pkg::S_RMD:   state_d = rhht_pkg::S_RMCHK;
      rhht_pkg::S_RMCHK: begin
        if (!valid_q[pos_q] || res_dist == '0 || steps_q[SB]) state_d = rhht_pkg::S_OUT;
        else state_d = rhht_pkg::S_RMD;
      end
      rhht_pkg::S_CLR:   state_d = rhht_pkg::S_OUT;
      rhht_pkg::S_OUT:   if (rsp.ready) state_d = rhht_pkg::S_IDLE;
      default:           state_d = rhht_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cur_d = cur_q; pos_d = pos_q; dist_d = dist_q; steps_d = steps_q;
    status_d = status_q; edata_d = edata_q;
    we = 1'b0; waddr = pos_q; wdata = cur_q;
    set_v = 1'b0; clr_v = 1'b0; clr_all = 1'b0; cnt_inc = 1'b0; cnt_dec = 1'b0;
    unique case (state_q)
      rhht_pkg::S_IDLE: begin
        cur_d = '{key: cmd.key, hash: cmd.hash_value, data: cmd.data_in};
        pos_d = cmd.hash_value[SB-1:0];
        dist_d = '0; steps_d = '0;
        status_d = rhht_pkg::StNotFound; edata_d = '0;
      end
      rhht_pkg::S_PCHK: begin
        if (!valid_q[pos_q] || hit || dist_q > res_dist || steps_q[SB]) begin
          steps_d = '0;
          if (hit) begin
            unique case (cmd_q)
              rhht_pkg::CmdLookup: begin status_d = rhht_pkg::StFound; edata_d = rdata.data; end
              rhht_pkg::CmdInsert: status_d = rhht_pkg::StDup;
              rhht_pkg::CmdRemove: begin
                status_d = rhht_pkg::StRemoved; edata_d = rdata.data;
                clr_v = 1'b1; cnt_dec = 1'b1; pos_d = nxt_q;
              end
              default: begin
                status_d = rhht_pkg::StUpdated; edata_d = rdata.data;
                we = 1'b1; wdata = '{key: rdata.key, hash: rdata.hash, data: cur_q.data};
              end
            endcase
          end else if (cmd_q == rhht_pkg::CmdInsert || cmd_q == rhht_pkg::CmdUpsert) begin
            if (full) status_d = rhht_pkg::StFull;
            else begin
              status_d = rhht_pkg::StInserted; edata_d = cur_q.data; cnt_inc = 1'b1;
            end
          end
        end else begin
          dist_d = dist_q + 1'b1; pos_d = nxt_q; steps_d = steps_q + 1'b1;
        end
      end
      rhht_pkg::S_PLCHK: begin
        // hold the probe stop slot's read data; swap when richer
        we = 1'b1; wdata = cur_q;
        if (!valid_q[pos_q]) begin
          set_v = 1'b1;
        end else if (dist_q > res_dist) begin
          cur_d = rdata; dist_d = res_dist + 1'b1; pos_d = nxt_q;
        end else begin
          we = 1'b0; dist_d = dist_q + 1'b1; pos_d = nxt_q;
        end
      end
      rhht_pkg::S_RMCHK: begin
        // pos_q is the follower; move it back one slot
        steps_d = steps_q + 1'b1;
        if (valid_q[pos_q] && res_dist != '0 && !steps_q[SB]) begin
          we = 1'b1; waddr = pos_q - 1'b1; wdata = rdata;
          set_v = 1'b1; clr_v = 1'b1; pos_d = nxt_q;
        end
      end
      rhht_pkg::S_CLR: begin
        clr_all = 1'b1; status_d = rhht_pkg::StCleared; edata_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rhht_pkg::S_IDLE;
      max_q <= 8'd192;
      valid_q <= '0;
      count_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) max_q <= cfg_wdata_i;
      if (clr_all) begin
        valid_q <= '0; count_q <= '0;
      end else begin
        valid_q <= (valid_q & ~clr_mask) | set_mask;
        if (cnt_inc) count_q <= count_q + 1'b1;
        if (cnt_dec) count_q <= count_q - 1'b1;
      end
      rsp_valid_q <= (state_d == rhht_pkg::S_OUT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rhht_pkg::S_IDLE) cmd_q <= cmd.command;
    cur_q <= cur_d; pos_q <= pos_d; dist_q <= dist_d; steps_q <= steps_d;
    status_q <= status_d; edata_q <= edata_d;
  end

  assign cmd.ready       = (state_q == rhht_pkg::S_IDLE);
  assign rsp.valid       = rsp_valid_q;
  assign rsp.status      = status_q;
  assign rsp.entry_data  = edata_q;
  assign rsp.entry_count = count_q;

  `RH_ASSERT(a_cnt_bound, clk_i, rst_ni, count_q <= rhht_pkg::CntBits'(rhht_pkg::Slots), "count overflow")
  `RH_ASSERT(a_rsp_state, clk_i, rst_ni, rsp_valid_q == (state_q == rhht_pkg::S_OUT), "response outside output state")
  `RH_ASSERT_NEXT(a_clear, clk_i, rst_ni, state_q == rhht_pkg::S_CLR, count_q == '0 && valid_q == '0, "clear left entries")
endmodule
`default_nettype wire

// ===== verif/robin_hood_hash_table_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module robin_hood_hash_table_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        cmd_valid_i,
  input  wire logic        cmd_ready_i,
  input  wire logic [2:0]  cmd_command_i,
  input  wire logic [31:0] cmd_key_i,
  input  wire logic [31:0] cmd_hash_i,
  input  wire logic [31:0] cmd_data_i,
  input  wire logic        rsp_valid_i,
  input  wire logic        rsp_ready_i,
  input  wire logic [2:0]  rsp_status_i,
  input  wire logic [31:0] rsp_entry_data_i,
  input  wire logic [8:0]  rsp_entry_count_i,
  output int               error_count_o,
  output int               pending_o,
  output int               words_seen_o
);
  import rhht_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] entry_data;
    logic [8:0]  entry_count;
  } answer_t;

  logic        tbl_valid [Slots];
  logic [31:0] tbl_key   [Slots];
  logic [31:0] tbl_hash  [Slots];
  logic [31:0] tbl_data  [Slots];
  int unsigned held_keys;
  logic [7:0]  key_limit;
  answer_t     answers_due [$];

  assign pending_o = answers_due.size();

  function automatic int unsigned home_dist(int unsigned p);
    return (p + Slots - (tbl_hash[p] % Slots)) % Slots;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count_o++;
  endtask

  task automatic wipe_table();
    for (int i = 0; i < Slots; i++) tbl_valid[i] = 1'b0;
    held_keys = 0;
  endtask

  // runs one command against the local table copy and queues its answer
  task automatic apply_command(input logic [2:0] op, input logic [31:0] k,
                               input logic [31:0] h, input logic [31:0] d);
    int unsigned p, walk_dist, ed, q;
    logic        hit;
    logic        full;
    logic [31:0] ck, ch, cd, tk, th, td;
    answer_t     a;
    a = '{status: StNotFound, entry_data: '0, entry_count: '0};
    full = (held_keys >= key_limit) || (held_keys >= Slots);
    hit = 1'b0;
    p = h % Slots;
    walk_dist = 0;
    if (op <= CmdRemove) begin
      for (int n = 0; n < Slots; n++) begin
        if (!tbl_valid[p]) break;
        if (tbl_hash[p] == h && tbl_key[p] == k) begin
          hit = 1'b1;
          break;
        end
        if (walk_dist <= home_dist(p)) begin
          walk_dist++;
          p = (p + 1) % Slots;
        end else break;
      end
    end
    case (op)
      CmdLookup: if (hit) begin
        a.status = StFound;
        a.entry_data = tbl_data[p];
      end
      CmdInsert, CmdUpsert: begin
        if (hit) begin
          if (op == CmdInsert) a.status = StDup;
          else begin
            a.status = StUpdated;
            a.entry_data = tbl_data[p];
            tbl_data[p] = d;
          end
        end else if (full) a.status = StFull;
        else begin
          ck = k; ch = h; cd = d;
          for (int n = 0; n < Slots; n++) begin
            if (!tbl_valid[p]) begin
              tbl_valid[p] = 1'b1;
              tbl_key[p] = ck; tbl_hash[p] = ch; tbl_data[p] = cd;
              break;
            end
            ed = home_dist(p);
            // richer resident gets displaced onward
            if (walk_dist > ed) begin
              tk = tbl_key[p]; th = tbl_hash[p]; td = tbl_data[p];
              tbl_key[p] = ck; tbl_hash[p] = ch; tbl_data[p] = cd;
              ck = tk; ch = th; cd = td;
              walk_dist = ed;
            end
            walk_dist++;
            p = (p + 1) % Slots;
          end
          held_keys++;
          a.status = StInserted;
          a.entry_data = d;
        end
      end
      CmdUpdate: if (hit) begin
        a.status = StUpdated;
        a.entry_data = tbl_data[p];
        tbl_data[p] = d;
      end
      CmdRemove: if (hit) begin
        a.status = StRemoved;
        a.entry_data = tbl_data[p];
        tbl_valid[p] = 1'b0;
        // backward shift until a gap or an entry at home
        for (int n = 0; n + 1 < Slots; n++) begin
          q = (p + 1) % Slots;
          if (!tbl_valid[q] || home_dist(q) == 0) break;
          tbl_valid[p] = 1'b1;
          tbl_key[p] = tbl_key[q]; tbl_hash[p] = tbl_hash[q]; tbl_data[p] = tbl_data[q];
          tbl_valid[q] = 1'b0;
          p = q;
        end
        if (held_keys > 0) held_keys--;
      end
      CmdClear: begin
        wipe_table();
        a.status = StCleared;
      end
      default: ;
    endcase
    a.entry_count = held_keys[8:0];
    answers_due.push_back(a);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      wipe_table();
      key_limit = 8'd192;
      answers_due.delete();
      error_count_o = 0;
      words_seen_o = 0;
    end else begin
      if (cfg_we_i) key_limit = cfg_wdata_i;
      if (cmd_valid_i && cmd_ready_i)
        apply_command(cmd_command_i, cmd_key_i, cmd_hash_i, cmd_data_i);
      if (rsp_valid_i && rsp_ready_i) begin
        words_seen_o++;
        if (answers_due.size() == 0) report("unexpected word", 0, 0);
        else begin
          want = answers_due.pop_front();
          if (rsp_status_i !== want.status) report("status", rsp_status_i, want.status);
          if (rsp_entry_data_i !== want.entry_data)
            report("entry_data", rsp_entry_data_i, want.entry_data);
          if (rsp_entry_count_i !== want.entry_count)
            report("entry_count", rsp_entry_count_i, want.entry_count);
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== verif/robin_hood_hash_table_top_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module robin_hood_hash_table_top_tb;
  import rhht_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = '0;
  int         error_count, pending, words_seen;
  int         idle_cycles;
  int         cmds_sent;
  logic       rsp_stall_on;

  rhht_cmd_if cmd ();
  rhht_rsp_if rsp ();

  robin_hood_hash_table_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd        (cmd.sink),
    .rsp        (rsp.source)
  );

  robin_hood_hash_table_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .cmd_valid_i      (cmd.valid),
    .cmd_ready_i      (cmd.ready),
    .cmd_command_i    (cmd.command),
    .cmd_key_i        (cmd.key),
    .cmd_hash_i       (cmd.hash_value),
    .cmd_data_i       (cmd.data_in),
    .rsp_valid_i      (rsp.valid),
    .rsp_ready_i      (rsp.ready),
    .rsp_status_i     (rsp.status),
    .rsp_entry_data_i (rsp.entry_data),
    .rsp_entry_count_i(rsp.entry_count),
    .error_count_o    (error_count),
    .pending_o        (pending),
    .words_seen_o     (words_seen)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    cmd.valid = 1'b0;
    cmd.command = CmdLookup;
    cmd.key = '0;
    cmd.hash_value = '0;
    cmd.data_in = '0;
    rsp.ready = 1'b0;
  end

  // watchdog: counts cycles without any accepted word; its limit covers the worst probe
  // plus walk or shift and the sender and receiver gaps with a wide margin
  always @(posedge clk_i) begin
    if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("watchdog expired");
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stall per word, with a stall-free stretch
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = rsp_stall_on ? $urandom_range(0, 19) : 0;
      if (gap != 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp.valid);
      @(negedge clk_i);
    end
  end

  // one command word; a gap is drawn per word when idle_on
  task automatic send_word(input logic [2:0] op, input logic [31:0] k,
                           input logic [31:0] h, input logic [31:0] d,
                           input bit idle_on);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd.valid <= 1'b1;
    cmd.command <= op;
    cmd.key <= k;
    cmd.hash_value <= h;
    cmd.data_in <= d;
    do @(posedge clk_i); while (!cmd.ready);
    @(negedge clk_i);
    cmds_sent++;
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // settings register write, only with the table idle
  task automatic set_limit(input logic [7:0] lim);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= lim;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // keys come from a small pool so lookups hit; hashes cluster on few homes
  logic [31:0] pool_key [32];
  logic [31:0] pool_hash [32];

  task automatic random_phase(input int count, input int pool_used, input bit idle_on);
    int          pick, sel;
    logic [2:0]  op;
    logic [31:0] k, h;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, pool_used - 1);
      k = pool_key[pick];
      h = pool_hash[pick];
      sel = $urandom_range(0, 99);
      if (sel < 30) op = CmdInsert;
      else if (sel < 50) op = CmdLookup;
      else if (sel < 60) op = CmdUpdate;
      else if (sel < 72) op = CmdUpsert;
      else if (sel < 92) op = CmdRemove;
      else if (sel < 93) op = CmdClear;
      else if (sel < 96) op = 3'($urandom_range(6, 7));
      else begin
        // noise: fully random key and hash
        op = 3'($urandom_range(0, 4));
        k = $urandom;
        h = $urandom;
      end
      // same key with another hash now and then, must not match
      if ($urandom_range(0, 30) == 0) h = h ^ 32'h100;
      send_word(op, k, h, $urandom, idle_on);
    end
  endtask

  initial begin
    cmds_sent = 0;
    rsp_stall_on = 1'b1;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, every command, open cases
    send_word(CmdLookup, 32'h0, 32'h0, 32'h0, 0);
    send_word(CmdInsert, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_word(CmdInsert, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234, 0);
    send_word(CmdInsert, 32'h0, 32'h0000_00FF, 32'h0, 0);
    send_word(CmdInsert, 32'h1, 32'h0000_01FF, 32'h5, 0);
    send_word(CmdInsert, 32'h2, 32'h0000_00FE, 32'h6, 0);
    send_word(CmdLookup, 32'h1, 32'h0000_01FF, 32'h0, 0);
    send_word(CmdLookup, 32'h1, 32'h0000_02FF, 32'h0, 0);
    send_word(CmdUpdate, 32'h1, 32'h0000_01FF, 32'hAAAA_5555, 0);
    send_word(CmdUpdate, 32'h77, 32'h77, 32'h1, 0);
    send_word(CmdUpsert, 32'h1, 32'h0000_01FF, 32'h5555_AAAA, 0);
    send_word(CmdUpsert, 32'h9, 32'h0000_00FF, 32'h9, 0);
    send_word(CmdRemove, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 0);
    send_word(CmdRemove, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 0);
    send_word(CmdLookup, 32'h9, 32'h0000_00FF, 32'h0, 0);
    send_word(3'd6, 32'h1, 32'h0000_01FF, 32'h0, 0);
    send_word(3'd7, 32'h1, 32'h0000_01FF, 32'h0, 0);
    send_word(CmdClear, 32'h0, 32'h0, 32'h0, 0);
    send_word(CmdLookup, 32'h1, 32'h0000_01FF, 32'h0, 0);

    // limit of 1, then lowered to zero, below the count
    set_limit(8'd1);
    send_word(CmdInsert, 32'h10, 32'h10, 32'h10, 0);
    send_word(CmdInsert, 32'h11, 32'h10, 32'h11, 0);
    send_word(CmdUpsert, 32'h12, 32'h10, 32'h12, 0);
    set_limit(8'd0);
    send_word(CmdInsert, 32'h13, 32'h13, 32'h13, 0);
    send_word(CmdRemove, 32'h10, 32'h10, 32'h0, 0);

    // random part, pools regenerated per phase with clustered homes
    set_limit(8'd255);
    for (int phase = 0; phase < 5; phase++) begin
      for (int i = 0; i < 32; i++) begin
        pool_key[i] = $urandom;
        pool_hash[i] = {24'($urandom_range(0, 32'hFF_FFFF)),
                        8'($urandom_range(250, 255) + phase)};
      end
      rsp_stall_on = (phase != 2);
      random_phase(160, (phase == 1) ? 32 : 24, phase != 3);
      // full sender pause until everything has come back
      drain();
      case (phase)
        0: set_limit(8'd4);
        1: set_limit(8'd20);
        2: set_limit(8'd255);
        default: set_limit(8'd192);
      endcase
    end

    // fill the table up to the limit of 255 entries with fully random hashes
    set_limit(8'd255);
    send_word(CmdClear, 32'h0, 32'h0, 32'h0, 0);
    for (int i = 0; i < 258; i++) send_word(CmdInsert, $urandom, $urandom, $urandom, 1);
    drain();

    $display("covered %0d commands, %0d result words, limits 0 1 4 20 192 255,",
             cmds_sent, words_seen);
    $display("clustered probes, displacement, backward shift, full and limit refusals");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
